/* design/slab_page_object_allocator_assert.svh */
// Assertion macros shared by the slab allocator RTL.
// Needs a clock and an active-low reset name at each use; no other dependencies.
`ifndef SLAB_PAGE_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_PAGE_OBJECT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SLAB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab allocator: same-cycle check failed");

// next-cycle implication
`define SLAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab allocator: next-cycle check failed");

`endif

/* design/slab_pkg.sv */
// Shared types and constants for the slab page object allocator.
// No dependencies; imported by every module of the block.
package slab_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int SLOTS_DEF      = 128;

    localparam int OBJ_W      = 12;
    localparam int PAGE_NUM_W = 52;
    localparam int ADDR_W     = 64;
    localparam int LIVE_OUT_W = 7;
    localparam int COUNT_W    = 8;
    localparam int LINK_W     = 8;
    localparam int SIZE_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int PN_SPLIT   = 26;
    localparam int HEADER_BYTES = 26;

    localparam logic [OBJ_W-1:0]  MIN_OBJ  = 12'd32;
    localparam logic [SIZE_W-1:0] MAX_OBJ  = 13'd4048;
    localparam logic [LINK_W-1:0] END_MARK = 8'd255;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_BAD_FREE = 2'd2
    } slab_status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } slab_op_t;

    typedef enum logic {
        CFG_OBJECT_SIZE = 1'b0,
        CFG_PAGE_NUMBER = 1'b1
    } slab_cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP_DIV,
        S_SETUP_WAIT,
        S_BASE_MUL,
        S_BASE_SUM,
        S_DISPATCH,
        S_ALLOC_RD,
        S_ALLOC_FIN,
        S_FREE_DIV,
        S_FREE_WAIT,
        S_FREE_FIN
    } slab_state_t;

    typedef struct packed {
        logic take;
        logic setup_div;
        logic setup_cap;
        logic base_mul;
        logic base_sum;
        logic alloc_rd;
        logic alloc_fin;
        logic free_div;
        logic free_fin;
    } slab_cmd_t;

    typedef struct packed {
        logic setup_needed;
        logic item_free;
        logic div_done;
        logic out_free;
    } slab_stat_t;

endpackage

/* design/slab_page_object_allocator.sv */
// Item path: accept, dispatch, then alloc reads the free link and finishes, while free runs the
// bit-serial divider (width max(12, log2 PAGE_BYTES), 12 at default) and finishes. After reset or
// a config write the next item first runs setup: divide, capacity, base multiply, base sum. One item at a time.
// Reset: control, counters and free-chain valid bits clear at once; no clearing pass.
// Config registers take their reset values (object_size 32, page_number 0).
module slab_page_object_allocator
    import slab_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int SLOTS      = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] free_offset
    input  logic                  s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // [63:0] object_address, [64] page_empty,
                                             // [71:65] live_objects
    output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [PAGE_NUM_W-1:0] cfg_data
);

`include "slab_page_object_allocator_assert.svh"

    slab_cmd_t             cmd;
    slab_stat_t            stat;
    slab_status_t          out_status;
    logic [ADDR_W-1:0]     out_addr;
    logic                  out_empty;
    logic [LIVE_OUT_W-1:0] out_live;
    logic                  empty_ok;

    slab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slab_dp #(
        .PAGE_BYTES (PAGE_BYTES),
        .SLOTS      (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (slab_op_t'(s_tuser)),
        .in_offset  (s_tdata[OBJ_W-1:0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_sel    (slab_cfg_idx_t'(cfg_index)),
        .cfg_value  (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_addr   (out_addr),
        .out_empty  (out_empty),
        .out_live   (out_live)
    );

    assign m_tdata = {out_live, out_empty, out_addr};
    assign m_tuser = out_status;

    // an empty page is only reported by a good free that left nothing live
    assign empty_ok = (out_status == ST_OK) && (out_live == '0);

    `SLAB_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SLAB_ASSERT_IMPLY(a_addr_only_ok, clk, rst_n, m_tvalid && (m_tuser != ST_OK), out_addr == '0)
    `SLAB_ASSERT_IMPLY(a_empty_clean, clk, rst_n, m_tvalid && out_empty, empty_ok)

endmodule

/* design/slab_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses slab_pkg for widths; instantiated by slab_dp.
module slab_div
    import slab_pkg::*;
#(
    parameter int DIV_W = OBJ_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [SIZE_W-1:0]  dsr_reg, dsr_next;
    logic [SIZE_W:0]    shifted;
    logic [SIZE_W:0]    diff;
    logic               fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/slab_dp.sv */
// Datapath: config registers, page geometry, free-link memory, counters, result register.
// Uses slab_pkg and slab_div; steered by slab_ctrl through slab_cmd_t / slab_stat_t.
module slab_dp
    import slab_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int SLOTS      = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  slab_cmd_t             cmd,
    output slab_stat_t            stat,
    input  slab_op_t              in_op,
    input  logic [OBJ_W-1:0]      in_offset,
    input  logic                  cfg_we,
    input  slab_cfg_idx_t         cfg_sel,
    input  logic [PAGE_NUM_W-1:0] cfg_value,
    input  logic                  out_ready,
    output logic                  out_valid,
    output slab_status_t          out_status,
    output logic [ADDR_W-1:0]     out_addr,
    output logic                  out_empty,
    output logic [LIVE_OUT_W-1:0] out_live
);

    localparam int DIV_W = ($clog2(PAGE_BYTES) > OBJ_W) ? $clog2(PAGE_BYTES) : OBJ_W;
    localparam int CAP_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int PB_W  = $clog2(PAGE_BYTES + 1);
    localparam int LO_W  = PN_SPLIT + PB_W;
    localparam int MUL_W = LINK_W + SIZE_W;

    // config and geometry
    logic [OBJ_W-1:0]      obj_size_reg, obj_size_next;
    logic [PAGE_NUM_W-1:0] page_num_reg, page_num_next;
    logic                  setup_needed_reg, setup_needed_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [OBJ_W-1:0]      area_reg;
    logic [LO_W-1:0]       prod_lo_reg, prod_hi_reg;
    logic [ADDR_W-1:0]     base_area_reg;

    // item
    slab_op_t              op_reg;
    logic [OBJ_W-1:0]      off_reg;

    // free list and count
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]    live_reg, live_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [LINK_W-1:0]     link_mem [SLOTS];
    logic [LINK_W-1:0]     mem_rd_reg;
    logic                  link_valid_reg;
    logic [LINK_W-1:0]     fresh_reg;
    logic [MUL_W-1:0]      mul_reg;
    logic                  room_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    slab_status_t          out_status_reg, out_status_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic                  out_empty_reg, out_empty_next;
    logic [LIVE_OUT_W-1:0] out_live_reg, out_live_next;

    // combinational
    logic [SIZE_W-1:0]     raised, eff;
    logic                  too_big;
    logic                  div_start, div_done;
    logic [DIV_W-1:0]      div_dividend, quotient;
    logic [SIZE_W-1:0]     div_divisor;
    logic [CAP_W-1:0]      cap_next;
    logic [OBJ_W-1:0]      area_next;
    logic [IDX_W-1:0]      hidx, widx;
    logic [LINK_W:0]       head_inc;
    logic [LINK_W-1:0]     fresh_link, link;
    logic                  free_ok, out_free;
    logic [COUNT_W-1:0]    live_after;

    // size raised to the minimum, then rounded up to 16
    assign raised  = (obj_size_reg < MIN_OBJ) ? SIZE_W'(MIN_OBJ) : SIZE_W'(obj_size_reg);
    assign eff     = (raised + SIZE_W'(15)) & ~SIZE_W'(15);
    assign too_big = eff > MAX_OBJ;

    assign div_start    = cmd.setup_div | cmd.free_div;
    assign div_dividend = cmd.setup_div ? DIV_W'(PAGE_BYTES - 32) : DIV_W'(off_reg - area_reg);
    assign div_divisor  = cmd.setup_div ? eff + SIZE_W'(1) : eff;

    slab_div #(.DIV_W(DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (too_big)
            cap_next = '0;
        else if (quotient > DIV_W'(SLOTS))
            cap_next = CAP_W'(SLOTS);
        else
            cap_next = CAP_W'(quotient);
        area_next = (OBJ_W'(HEADER_BYTES) + OBJ_W'(cap_next) + OBJ_W'(15)) & ~OBJ_W'(15);
    end

    // entry that was never pushed reads as the fresh chain
    assign hidx       = head_reg[IDX_W-1:0];
    assign head_inc   = (LINK_W + 1)'(head_reg) + 1'b1;
    assign fresh_link = (head_inc < (LINK_W + 1)'(cap_reg)) ? LINK_W'(head_inc) : END_MARK;
    assign link       = link_valid_reg ? mem_rd_reg : fresh_reg;

    assign widx    = quotient[IDX_W-1:0];
    assign free_ok = (off_reg >= area_reg) && (live_reg != '0)
                  && (quotient < DIV_W'(cap_reg));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        obj_size_next     = obj_size_reg;
        page_num_next     = page_num_reg;
        setup_needed_next = setup_needed_reg;
        head_next         = head_reg;
        live_next         = live_reg;
        valid_next        = valid_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_status_next   = out_status_reg;
        out_addr_next     = out_addr_reg;
        out_empty_next    = out_empty_reg;
        out_live_next     = out_live_reg;
        live_after        = live_reg;

        if (cfg_we)
        begin
            setup_needed_next = 1'b1;
            unique case (cfg_sel)
                CFG_OBJECT_SIZE:
                begin
                    obj_size_next = cfg_value[OBJ_W-1:0];
                    live_next     = '0;
                    head_next     = '0;
                    valid_next    = '0;
                end
                CFG_PAGE_NUMBER: page_num_next = cfg_value;
                default: ;
            endcase
        end

        if (cmd.base_sum)
            setup_needed_next = 1'b0;

        if (cmd.alloc_fin)
        begin
            out_valid_next = 1'b1;
            out_empty_next = 1'b0;
            if (room_reg)
            begin
                live_after      = live_reg + 1'b1;
                head_next       = link;
                out_status_next = ST_OK;
                out_addr_next   = base_area_reg + ADDR_W'(mul_reg);
            end
            else
            begin
                out_status_next = ST_NO_ROOM;
                out_addr_next   = '0;
            end
            live_next     = live_after;
            out_live_next = live_after[LIVE_OUT_W-1:0];
        end

        if (cmd.free_fin)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = '0;
            out_empty_next = 1'b0;
            if (free_ok)
            begin
                live_after      = live_reg - 1'b1;
                out_status_next = ST_OK;
                if (live_after == '0)
                begin
                    // last object back: chain starts fresh
                    out_empty_next = 1'b1;
                    head_next      = '0;
                    valid_next     = '0;
                end
                else
                begin
                    head_next        = LINK_W'(widx);
                    valid_next[widx] = 1'b1;
                end
            end
            else
                out_status_next = ST_BAD_FREE;
            live_next     = live_after;
            out_live_next = live_after[LIVE_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_size_reg     <= OBJ_W'(MIN_OBJ);
            page_num_reg     <= '0;
            setup_needed_reg <= 1'b1;
            head_reg         <= '0;
            live_reg         <= '0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            obj_size_reg     <= obj_size_next;
            page_num_reg     <= page_num_next;
            setup_needed_reg <= setup_needed_next;
            head_reg         <= head_next;
            live_reg         <= live_next;
            valid_reg        <= valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_empty_reg  <= out_empty_next;
        out_live_reg   <= out_live_next;
        if (cmd.take)
        begin
            op_reg  <= in_op;
            off_reg <= in_offset;
        end
        if (cmd.setup_cap)
        begin
            cap_reg  <= cap_next;
            area_reg <= area_next;
        end
        if (cmd.base_mul)
        begin
            prod_lo_reg <= LO_W'(page_num_reg[PN_SPLIT-1:0]) * LO_W'(PAGE_BYTES);
            prod_hi_reg <= LO_W'(page_num_reg[PAGE_NUM_W-1:PN_SPLIT]) * LO_W'(PAGE_BYTES);
        end
        if (cmd.base_sum)
            base_area_reg <= ADDR_W'(prod_lo_reg) + (ADDR_W'(prod_hi_reg) << PN_SPLIT)
                           + ADDR_W'(area_reg);
        if (cmd.alloc_rd)
        begin
            link_valid_reg <= valid_reg[hidx];
            fresh_reg      <= fresh_link;
            mul_reg        <= MUL_W'(head_reg) * MUL_W'(eff);
            room_reg       <= head_reg < LINK_W'(cap_reg);
        end
    end

    // free-link memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_rd)
            mem_rd_reg <= link_mem[hidx];
        if (cmd.free_fin && free_ok)
            link_mem[widx] <= head_reg;
    end

    always_comb
    begin
        stat.setup_needed = setup_needed_reg;
        stat.item_free    = (op_reg == CMD_FREE);
        stat.div_done     = div_done;
        stat.out_free     = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_empty  = out_empty_reg;
    assign out_live   = out_live_reg;

endmodule

/* design/slab_ctrl.sv */
// Controller state machine for the slab allocator.
// Uses slab_pkg; drives slab_dp through slab_cmd_t and reads slab_stat_t.
module slab_ctrl
    import slab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       cfg_ready,
    input  slab_stat_t stat,
    output slab_cmd_t  cmd
);

    slab_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = stat.setup_needed ? S_SETUP_DIV : S_DISPATCH;
                end
            end
            S_SETUP_DIV:
            begin
                cmd.setup_div = 1'b1;
                state_next    = S_SETUP_WAIT;
            end
            S_SETUP_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.setup_cap = 1'b1;
                    state_next    = S_BASE_MUL;
                end
            end
            S_BASE_MUL:
            begin
                cmd.base_mul = 1'b1;
                state_next   = S_BASE_SUM;
            end
            S_BASE_SUM:
            begin
                cmd.base_sum = 1'b1;
                state_next   = S_DISPATCH;
            end
            S_DISPATCH:
                state_next = stat.item_free ? S_FREE_DIV : S_ALLOC_RD;
            S_ALLOC_RD:
            begin
                cmd.alloc_rd = 1'b1;
                state_next   = S_ALLOC_FIN;
            end
            S_ALLOC_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.alloc_fin = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FREE_DIV:
            begin
                cmd.free_div = 1'b1;
                state_next   = S_FREE_WAIT;
            end
            S_FREE_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_FREE_FIN;
            end
            S_FREE_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.free_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
